[rtl/core/tlic_pkg.sv]
package tlic_pkg;

   localparam int ADDR_W      = 11;
   localparam int LINE_IDX_W  = 9;
   localparam int DATA_W      = 32;
   localparam int CH_IDX_W    = 5;
   localparam int EN_W        = 16;
   localparam int BIT_IDX_W   = 4;
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

   localparam int CH_STRIDE_SHIFT = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REQ_TUSER_W-1:0] REQ_LINE  = 2'd0;
   localparam logic [REQ_TUSER_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_TUSER_W-1:0] REQ_WRITE = 2'd2;

   localparam logic [ADDR_W-1:0] OFS_IRQ_STATUS = 11'h000;
   localparam logic [ADDR_W-1:0] OFS_FIQ_STATUS = 11'h004;
   localparam logic [ADDR_W-1:0] OFS_SUMMARY    = 11'h008;
   localparam logic [ADDR_W-1:0] OFS_FAST_SEL   = 11'h00C;
   localparam logic [ADDR_W-1:0] OFS_TOP_EN     = 11'h010;
   localparam logic [ADDR_W-1:0] OFS_TOP_EN_CLR = 11'h014;
   localparam logic [ADDR_W-1:0] CH_BASE        = 11'h100;
   localparam logic [ADDR_W-1:0] CH_END         = 11'h500;

   localparam logic [CH_STRIDE_SHIFT-1:0] CH_OFS_RAW    = 5'h00;
   localparam logic [CH_STRIDE_SHIFT-1:0] CH_OFS_MASKED = 5'h04;
   localparam logic [CH_STRIDE_SHIFT-1:0] CH_OFS_EN     = 5'h08;
   localparam logic [CH_STRIDE_SHIFT-1:0] CH_OFS_EN_CLR = 5'h0C;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LINE_SET,
      OP_LINE_CLR,
      OP_RD_IRQ,
      OP_RD_FIQ,
      OP_RD_SUM,
      OP_RD_FSEL,
      OP_RD_TEN,
      OP_WR_FSEL,
      OP_WR_TEN_SET,
      OP_WR_TEN_CLR,
      OP_RD_CH_RAW,
      OP_RD_CH_MASKED,
      OP_RD_CH_EN,
      OP_WR_EN_SET,
      OP_WR_EN_CLR
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CH_IDX_W-1:0] ch;
      logic [DATA_W-1:0]   data;
   } cmd_type;

endpackage

[rtl/core/tlic_front.sv]
module tlic_front #(
   parameter int NUM_CHANNELS      = 32,
   parameter int LINES_PER_CHANNEL = 16
) (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: line_index[8:0], line_level[9], address[20:10],
   // write_data[52:21], zero fill.
   input  logic [tlic_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // Fields from bit 0: req_type[1:0].
   input  logic [tlic_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic                                 queue_full,
   output logic                                 push,
   output tlic_pkg::cmd_type                    push_cmd
);

   logic [tlic_pkg::LINE_IDX_W-1:0]             line_index;
   logic                                        line_level;
   logic [tlic_pkg::ADDR_W-1:0]                 address;
   logic [tlic_pkg::DATA_W-1:0]                 write_data;
   logic                                        line_hit;
   logic [tlic_pkg::CH_IDX_W-1:0]               line_ch;
   logic [tlic_pkg::BIT_IDX_W-1:0]              line_bit;
   logic                                        in_ch_region;
   logic [tlic_pkg::ADDR_W-tlic_pkg::CH_STRIDE_SHIFT-1:0] addr_ch;
   logic                                        addr_ch_ok;
   logic [tlic_pkg::CH_STRIDE_SHIFT-1:0]        addr_ofs;

   assign line_index = req_tdata[8:0];
   assign line_level = req_tdata[9];
   assign address    = req_tdata[20:10];
   assign write_data = req_tdata[52:21];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      line_hit = 1'b0;
      line_ch  = '0;
      line_bit = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if ({1'b0, line_index} >= 10'(c * LINES_PER_CHANNEL) &&
             {1'b0, line_index} < 10'((c + 1) * LINES_PER_CHANNEL)) begin
            line_hit = 1'b1;
            line_ch  = tlic_pkg::CH_IDX_W'(c);
            line_bit = tlic_pkg::BIT_IDX_W'(line_index -
                       tlic_pkg::LINE_IDX_W'(c * LINES_PER_CHANNEL));
         end
      end
   end

   assign in_ch_region = address >= tlic_pkg::CH_BASE && address < tlic_pkg::CH_END;
   assign addr_ch      = address[tlic_pkg::ADDR_W-1:tlic_pkg::CH_STRIDE_SHIFT] -
                         tlic_pkg::CH_BASE[tlic_pkg::ADDR_W-1:tlic_pkg::CH_STRIDE_SHIFT];
   assign addr_ch_ok   = addr_ch < (tlic_pkg::ADDR_W - tlic_pkg::CH_STRIDE_SHIFT)'(NUM_CHANNELS);
   assign addr_ofs     = address[tlic_pkg::CH_STRIDE_SHIFT-1:0];

   always_comb begin
      push_cmd.op   = tlic_pkg::OP_NOP;
      push_cmd.ch   = '0;
      push_cmd.data = write_data;
      unique case (req_tuser)
         tlic_pkg::REQ_LINE: begin
            push_cmd.ch   = line_ch;
            push_cmd.data = tlic_pkg::DATA_W'(1) << line_bit;
            if (line_hit) begin
               push_cmd.op = line_level ? tlic_pkg::OP_LINE_SET : tlic_pkg::OP_LINE_CLR;
            end
         end
         tlic_pkg::REQ_READ: begin
            push_cmd.ch = addr_ch[tlic_pkg::CH_IDX_W-1:0];
            priority if (in_ch_region) begin
               if (addr_ch_ok) begin
                  priority if (addr_ofs == tlic_pkg::CH_OFS_RAW) begin
                     push_cmd.op = tlic_pkg::OP_RD_CH_RAW;
                  end else if (addr_ofs == tlic_pkg::CH_OFS_MASKED) begin
                     push_cmd.op = tlic_pkg::OP_RD_CH_MASKED;
                  end else if (addr_ofs == tlic_pkg::CH_OFS_EN) begin
                     push_cmd.op = tlic_pkg::OP_RD_CH_EN;
                  end else begin
                     push_cmd.op = tlic_pkg::OP_NOP;
                  end
               end
            end else if (address == tlic_pkg::OFS_IRQ_STATUS) begin
               push_cmd.op = tlic_pkg::OP_RD_IRQ;
            end else if (address == tlic_pkg::OFS_FIQ_STATUS) begin
               push_cmd.op = tlic_pkg::OP_RD_FIQ;
            end else if (address == tlic_pkg::OFS_SUMMARY) begin
               push_cmd.op = tlic_pkg::OP_RD_SUM;
            end else if (address == tlic_pkg::OFS_FAST_SEL) begin
               push_cmd.op = tlic_pkg::OP_RD_FSEL;
            end else if (address == tlic_pkg::OFS_TOP_EN) begin
               push_cmd.op = tlic_pkg::OP_RD_TEN;
            end else begin
               push_cmd.op = tlic_pkg::OP_NOP;
            end
         end
         tlic_pkg::REQ_WRITE: begin
            push_cmd.ch = addr_ch[tlic_pkg::CH_IDX_W-1:0];
            priority if (in_ch_region) begin
               if (addr_ch_ok) begin
                  priority if (addr_ofs == tlic_pkg::CH_OFS_EN) begin
                     push_cmd.op = tlic_pkg::OP_WR_EN_SET;
                  end else if (addr_ofs == tlic_pkg::CH_OFS_EN_CLR) begin
                     push_cmd.op = tlic_pkg::OP_WR_EN_CLR;
                  end else begin
                     push_cmd.op = tlic_pkg::OP_NOP;
                  end
               end
            end else if (address == tlic_pkg::OFS_FAST_SEL) begin
               push_cmd.op = tlic_pkg::OP_WR_FSEL;
            end else if (address == tlic_pkg::OFS_TOP_EN) begin
               push_cmd.op = tlic_pkg::OP_WR_TEN_SET;
            end else if (address == tlic_pkg::OFS_TOP_EN_CLR) begin
               push_cmd.op = tlic_pkg::OP_WR_TEN_CLR;
            end else begin
               push_cmd.op = tlic_pkg::OP_NOP;
            end
         end
         default: begin
            push_cmd.op = tlic_pkg::OP_NOP;
         end
      endcase
   end

endmodule

[rtl/core/tlic_queue.sv]
module tlic_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tlic_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output tlic_pkg::cmd_type pop_cmd
);

   tlic_pkg::cmd_type                entries_ff [tlic_pkg::QUEUE_DEPTH];
   logic [tlic_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [tlic_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [tlic_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [tlic_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [tlic_pkg::QCNT_W-1:0]      count_ff;
   logic [tlic_pkg::QCNT_W-1:0]      count_in;

   assign full    = count_ff == tlic_pkg::QCNT_W'(tlic_pkg::QUEUE_DEPTH);
   assign valid   = count_ff != '0;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tlic_pkg::QPTR_W'(tlic_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tlic_pkg::QPTR_W'(tlic_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/tlic_back.sv]
module tlic_back #(
   parameter int NUM_CHANNELS      = 32,
   parameter int LINES_PER_CHANNEL = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  tlic_pkg::cmd_type                cmd,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: read_data[31:0], irq_out[32], fiq_out[33], zero fill.
   output logic [tlic_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [LINES_PER_CHANNEL-1:0]    status_ff [NUM_CHANNELS];
   logic [LINES_PER_CHANNEL-1:0]    status_in [NUM_CHANNELS];
   logic [tlic_pkg::EN_W-1:0]       enable_ff [NUM_CHANNELS];
   logic [tlic_pkg::EN_W-1:0]       enable_in [NUM_CHANNELS];
   logic [tlic_pkg::DATA_W-1:0]     top_en_ff;
   logic [tlic_pkg::DATA_W-1:0]     top_en_in;
   logic [tlic_pkg::DATA_W-1:0]     fsel_ff;
   logic [tlic_pkg::DATA_W-1:0]     fsel_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [tlic_pkg::DATA_W-1:0]     read_data_ff;
   logic [tlic_pkg::DATA_W-1:0]     read_data_in;
   logic                            irq_ff;
   logic                            irq_in;
   logic                            fiq_ff;
   logic                            fiq_in;
   logic [CH_W-1:0]                 ch;
   logic [LINES_PER_CHANNEL-1:0]    cur_status;
   logic [tlic_pkg::EN_W-1:0]       cur_enable;
   logic [tlic_pkg::DATA_W-1:0]     sum_cur;
   logic [tlic_pkg::DATA_W-1:0]     sum_next;
   logic [tlic_pkg::DATA_W-1:0]     read_val;

   assign pop        = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign ch         = cmd.ch[CH_W-1:0];
   assign cur_status = status_ff[ch];
   assign cur_enable = enable_ff[ch];

   always_comb begin
      sum_cur  = '0;
      sum_next = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sum_cur[c]  = |(status_ff[c] & enable_ff[c][LINES_PER_CHANNEL-1:0]);
         sum_next[c] = |(status_in[c] & enable_in[c][LINES_PER_CHANNEL-1:0]);
      end
   end

   always_comb begin
      status_in = status_ff;
      enable_in = enable_ff;
      top_en_in = top_en_ff;
      fsel_in   = fsel_ff;
      read_val  = '0;
      if (pop) begin
         unique case (cmd.op)
            tlic_pkg::OP_LINE_SET: begin
               status_in[ch] = cur_status | cmd.data[LINES_PER_CHANNEL-1:0];
            end
            tlic_pkg::OP_LINE_CLR: begin
               status_in[ch] = cur_status & ~cmd.data[LINES_PER_CHANNEL-1:0];
            end
            tlic_pkg::OP_RD_IRQ:       read_val = sum_cur & top_en_ff & ~fsel_ff;
            tlic_pkg::OP_RD_FIQ:       read_val = sum_cur & top_en_ff & fsel_ff;
            tlic_pkg::OP_RD_SUM:       read_val = sum_cur;
            tlic_pkg::OP_RD_FSEL:      read_val = fsel_ff;
            tlic_pkg::OP_RD_TEN:       read_val = top_en_ff;
            tlic_pkg::OP_WR_FSEL:      fsel_in = cmd.data;
            tlic_pkg::OP_WR_TEN_SET:   top_en_in = top_en_ff | cmd.data;
            tlic_pkg::OP_WR_TEN_CLR:   top_en_in = top_en_ff & ~cmd.data;
            tlic_pkg::OP_RD_CH_RAW:    read_val = tlic_pkg::DATA_W'(cur_status);
            tlic_pkg::OP_RD_CH_MASKED: begin
               read_val = tlic_pkg::DATA_W'(cur_status &
                          cur_enable[LINES_PER_CHANNEL-1:0]);
            end
            tlic_pkg::OP_RD_CH_EN:     read_val = tlic_pkg::DATA_W'(cur_enable);
            tlic_pkg::OP_WR_EN_SET: begin
               enable_in[ch] = cur_enable | cmd.data[tlic_pkg::EN_W-1:0];
            end
            tlic_pkg::OP_WR_EN_CLR: begin
               enable_in[ch] = cur_enable & ~cmd.data[tlic_pkg::EN_W-1:0];
            end
            default: read_val = '0;
         endcase
      end
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);
   assign read_data_in = pop ? read_val : read_data_ff;
   assign irq_in       = pop ? |(sum_next & top_en_in & ~fsel_in) : irq_ff;
   assign fiq_in       = pop ? |(sum_next & top_en_in & fsel_in) : fiq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            status_ff[c] <= '0;
            enable_ff[c] <= '1;
         end
         top_en_ff    <= '1;
         fsel_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         status_ff    <= status_in;
         enable_ff    <= enable_in;
         top_en_ff    <= top_en_in;
         fsel_ff      <= fsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      irq_ff       <= irq_in;
      fiq_ff       <= fiq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, fiq_ff, irq_ff, read_data_ff};

endmodule

[rtl/core/two_level_interrupt_controller.sv]
// Two-level interrupt controller: each request beat is a line level change, a register
// read or a register write, and each one yields exactly one response beat carrying the
// read data (zero unless it was a read) and the IRQ and FIQ levels after that beat took
// effect. An accepted beat passes through the two-entry command queue behind the decoder
// and then the response register before its response is shown, and the block takes one
// beat every cycle as long as responses are taken. When responses stall, up to three
// beats are held, two in the queue and one in the response register, before req_tready
// drops. All state comes out of reset ready to use, so there is no initialization period.
module two_level_interrupt_controller #(
   parameter int NUM_CHANNELS      = 32,
   parameter int LINES_PER_CHANNEL = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: line_index[8:0], line_level[9], address[20:10],
   // write_data[52:21], zero fill.
   input  logic [tlic_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: req_type[1:0].
   input  logic [tlic_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: read_data[31:0], irq_out[32], fiq_out[33], zero fill.
   output logic [tlic_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic              queue_full;
   logic              push;
   tlic_pkg::cmd_type push_cmd;
   logic              pop;
   logic              cmd_valid;
   tlic_pkg::cmd_type cmd;

   tlic_front #(
      .NUM_CHANNELS      (NUM_CHANNELS),
      .LINES_PER_CHANNEL (LINES_PER_CHANNEL)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tlic_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .valid    (cmd_valid),
      .pop_cmd  (cmd)
   );

   tlic_back #(
      .NUM_CHANNELS      (NUM_CHANNELS),
      .LINES_PER_CHANNEL (LINES_PER_CHANNEL)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/tlic_checker.sv]
module tlic_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [tlic_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [tlic_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tlic_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // An empty response register means the queue drained, so a request can always enter.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side stalled while the response side was empty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("stalled request beat changed or vanished");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response beat shown right after reset");

endmodule

bind two_level_interrupt_controller tlic_checker u_tlic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int LINES_PER_CH     = 16;
   localparam int CHANNELS         = 32;
   localparam int DIRECTED_ROWS    = 26;
   localparam int RANDOM_PER_PHASE = 625;
   localparam int HOLD_CYCLES      = 60;
   localparam int DRAIN_CYCLES     = 10;
   localparam int CYCLE_LIMIT      = 400000;

   localparam logic [tlic_pkg::REQ_TUSER_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [tlic_pkg::REQ_TUSER_W-1:0] kind;
      logic [tlic_pkg::LINE_IDX_W-1:0]  idx;
      logic                             lvl;
      logic [tlic_pkg::ADDR_W-1:0]      addr;
      logic [tlic_pkg::DATA_W-1:0]      data;
   } req_beat_type;

   typedef struct packed {
      logic [tlic_pkg::DATA_W-1:0] rd;
      logic                        irq;
      logic                        fiq;
   } rsp_beat_type;

   typedef struct packed {
      req_beat_type req;
      logic         typed;
      rsp_beat_type rsp;
   } stim_row_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [tlic_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [tlic_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [tlic_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   logic [tlic_pkg::EN_W-1:0]   line_stat [CHANNELS];
   logic [tlic_pkg::EN_W-1:0]   chan_en [CHANNELS];
   logic [tlic_pkg::DATA_W-1:0] top_en;
   logic [tlic_pkg::DATA_W-1:0] fast_sel;

   rsp_beat_type rsp_due[$];
   stim_row_type stim_rows [DIRECTED_ROWS];
   int           fails         = 0;
   int           cycles        = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_asked    = 0;
   int           hold_taken    = 0;

   two_level_interrupt_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic logic [tlic_pkg::ADDR_W-1:0] chan_addr(
      input int ch, input logic [tlic_pkg::CH_STRIDE_SHIFT-1:0] ofs);
      return tlic_pkg::CH_BASE + tlic_pkg::ADDR_W'(ch << tlic_pkg::CH_STRIDE_SHIFT) +
             tlic_pkg::ADDR_W'(ofs);
   endfunction

   function automatic logic [tlic_pkg::DATA_W-1:0] pending_channels();
      logic [tlic_pkg::DATA_W-1:0] sum;
      sum = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         sum[c] = |(line_stat[c] & chan_en[c]);
      end
      return sum;
   endfunction

   function automatic logic [tlic_pkg::DATA_W-1:0] read_reg(
      input logic [tlic_pkg::ADDR_W-1:0] addr);
      logic [tlic_pkg::ADDR_W-1:0]          rel;
      logic [tlic_pkg::CH_IDX_W-1:0]        ch;
      logic [tlic_pkg::CH_STRIDE_SHIFT-1:0] ofs;
      if (addr >= tlic_pkg::CH_BASE && addr < tlic_pkg::CH_END) begin
         rel = addr - tlic_pkg::CH_BASE;
         ch  = rel[tlic_pkg::CH_STRIDE_SHIFT +: tlic_pkg::CH_IDX_W];
         ofs = rel[tlic_pkg::CH_STRIDE_SHIFT-1:0];
         case (ofs)
            tlic_pkg::CH_OFS_RAW:    return tlic_pkg::DATA_W'(line_stat[ch]);
            tlic_pkg::CH_OFS_MASKED: return tlic_pkg::DATA_W'(line_stat[ch] & chan_en[ch]);
            tlic_pkg::CH_OFS_EN:     return tlic_pkg::DATA_W'(chan_en[ch]);
            default:                 return '0;
         endcase
      end
      case (addr)
         tlic_pkg::OFS_IRQ_STATUS: return pending_channels() & top_en & ~fast_sel;
         tlic_pkg::OFS_FIQ_STATUS: return pending_channels() & top_en & fast_sel;
         tlic_pkg::OFS_SUMMARY:    return pending_channels();
         tlic_pkg::OFS_FAST_SEL:   return fast_sel;
         tlic_pkg::OFS_TOP_EN:     return top_en;
         default:                  return '0;
      endcase
   endfunction

   function automatic void write_reg(input logic [tlic_pkg::ADDR_W-1:0] addr,
                                     input logic [tlic_pkg::DATA_W-1:0] data);
      logic [tlic_pkg::ADDR_W-1:0]          rel;
      logic [tlic_pkg::CH_IDX_W-1:0]        ch;
      logic [tlic_pkg::CH_STRIDE_SHIFT-1:0] ofs;
      if (addr >= tlic_pkg::CH_BASE && addr < tlic_pkg::CH_END) begin
         rel = addr - tlic_pkg::CH_BASE;
         ch  = rel[tlic_pkg::CH_STRIDE_SHIFT +: tlic_pkg::CH_IDX_W];
         ofs = rel[tlic_pkg::CH_STRIDE_SHIFT-1:0];
         if (ofs == tlic_pkg::CH_OFS_EN) begin
            chan_en[ch] = chan_en[ch] | data[tlic_pkg::EN_W-1:0];
         end else if (ofs == tlic_pkg::CH_OFS_EN_CLR) begin
            chan_en[ch] = chan_en[ch] & ~data[tlic_pkg::EN_W-1:0];
         end
      end else begin
         case (addr)
            tlic_pkg::OFS_FAST_SEL:   fast_sel = data;
            tlic_pkg::OFS_TOP_EN:     top_en = top_en | data;
            tlic_pkg::OFS_TOP_EN_CLR: top_en = top_en & ~data;
            default: ;
         endcase
      end
   endfunction

   function automatic rsp_beat_type apply_beat(input req_beat_type b);
      rsp_beat_type                r;
      logic [tlic_pkg::DATA_W-1:0] routed;
      r = '0;
      case (b.kind)
         tlic_pkg::REQ_LINE: begin
            line_stat[b.idx[tlic_pkg::LINE_IDX_W-1:tlic_pkg::BIT_IDX_W]]
                     [b.idx[tlic_pkg::BIT_IDX_W-1:0]] = b.lvl;
         end
         tlic_pkg::REQ_READ:  r.rd = read_reg(b.addr);
         tlic_pkg::REQ_WRITE: write_reg(b.addr, b.data);
         default: ;
      endcase
      routed = pending_channels() & top_en;
      r.irq  = |(routed & ~fast_sel);
      r.fiq  = |(routed & fast_sel);
      return r;
   endfunction

   function automatic logic [tlic_pkg::ADDR_W-1:0] pick_addr();
      logic [tlic_pkg::ADDR_W-1:0]          a;
      logic [tlic_pkg::CH_STRIDE_SHIFT-1:0] ofs;
      int                                   ch;
      ch = $urandom_range(CHANNELS - 1);
      case ($urandom_range(3))
         0:       ofs = tlic_pkg::CH_OFS_RAW;
         1:       ofs = tlic_pkg::CH_OFS_MASKED;
         2:       ofs = tlic_pkg::CH_OFS_EN;
         default: ofs = tlic_pkg::CH_OFS_EN_CLR;
      endcase
      case ($urandom_range(9))
         0, 1, 2: begin
            case ($urandom_range(5))
               0:       a = tlic_pkg::OFS_IRQ_STATUS;
               1:       a = tlic_pkg::OFS_FIQ_STATUS;
               2:       a = tlic_pkg::OFS_SUMMARY;
               3:       a = tlic_pkg::OFS_FAST_SEL;
               4:       a = tlic_pkg::OFS_TOP_EN;
               default: a = tlic_pkg::OFS_TOP_EN_CLR;
            endcase
         end
         3, 4, 5, 6, 7: a = chan_addr(ch, ofs);
         8:       a = chan_addr(ch, tlic_pkg::CH_STRIDE_SHIFT'($urandom_range(31)));
         default: a = tlic_pkg::ADDR_W'($urandom_range(2047));
      endcase
      return a;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      int           pick;
      pick   = $urandom_range(99);
      b.kind = (pick < 40) ? tlic_pkg::REQ_LINE : (pick < 70) ? tlic_pkg::REQ_READ :
               (pick < 95) ? tlic_pkg::REQ_WRITE : REQ_UNUSED;
      b.idx  = tlic_pkg::LINE_IDX_W'($urandom_range(511));
      b.lvl  = 1'($urandom_range(1));
      b.addr = pick_addr();
      b.data = $urandom();
      if ($urandom_range(1) == 1) begin
         b.data = b.data & $urandom() & $urandom();
      end
      return b;
   endfunction

   task automatic deliver(input req_beat_type b, input logic typed,
                          input rsp_beat_type typed_rsp);
      rsp_beat_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.kind;
      req_tdata  <= tlic_pkg::REQ_TDATA_W'({b.data, b.addr, b.lvl, b.idx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_beat(b);
      rsp_due.push_back(typed ? typed_rsp : predicted);
   endtask

   initial begin
      for (int c = 0; c < CHANNELS; c++) begin
         line_stat[c] = '0;
         chan_en[c]   = '1;
      end
      top_en   = '1;
      fast_sel = '0;
      stim_rows = '{
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, tlic_pkg::OFS_TOP_EN, 32'h0}, 1'b1,
           '{32'hffff_ffff, 1'b0, 1'b0}},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, tlic_pkg::OFS_FAST_SEL, 32'h0}, 1'b1,
           '{32'h0, 1'b0, 1'b0}},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, chan_addr(0, tlic_pkg::CH_OFS_EN), 32'h0},
           1'b1, '{32'h0000_ffff, 1'b0, 1'b0}},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, chan_addr(31, tlic_pkg::CH_OFS_EN), 32'h0},
           1'b1, '{32'h0000_ffff, 1'b0, 1'b0}},
         '{'{tlic_pkg::REQ_LINE, 9'd0, 1'b1, 11'h0, 32'h0}, 1'b1, '{32'h0, 1'b1, 1'b0}},
         '{'{tlic_pkg::REQ_LINE, 9'd511, 1'b1, 11'h0, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, tlic_pkg::OFS_SUMMARY, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_WRITE, 9'd0, 1'b0, tlic_pkg::OFS_FAST_SEL, 32'hffff_ffff},
           1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, tlic_pkg::OFS_FIQ_STATUS, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, tlic_pkg::OFS_IRQ_STATUS, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_WRITE, 9'd0, 1'b0, tlic_pkg::OFS_TOP_EN_CLR, 32'h8000_0000},
           1'b0, '0},
         '{'{tlic_pkg::REQ_WRITE, 9'd0, 1'b0, chan_addr(0, tlic_pkg::CH_OFS_EN_CLR),
             32'hffff_ffff}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, chan_addr(0, tlic_pkg::CH_OFS_MASKED), 32'h0},
           1'b0, '0},
         '{'{tlic_pkg::REQ_WRITE, 9'd0, 1'b0, chan_addr(0, tlic_pkg::CH_OFS_EN),
             32'hffff_0001}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, chan_addr(0, tlic_pkg::CH_OFS_EN), 32'h0},
           1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, tlic_pkg::CH_END, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, 11'h7ff, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, tlic_pkg::OFS_TOP_EN_CLR, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, chan_addr(31, tlic_pkg::CH_OFS_EN_CLR), 32'h0},
           1'b0, '0},
         '{'{tlic_pkg::REQ_WRITE, 9'd0, 1'b0, tlic_pkg::OFS_IRQ_STATUS, 32'hffff_ffff},
           1'b0, '0},
         '{'{tlic_pkg::REQ_WRITE, 9'd0, 1'b0, tlic_pkg::OFS_TOP_EN, 32'hffff_ffff},
           1'b0, '0},
         '{'{REQ_UNUSED, 9'd511, 1'b1, 11'h7ff, 32'hffff_ffff}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, tlic_pkg::CH_BASE + 11'd1, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_LINE, 9'd511, 1'b0, 11'h0, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_WRITE, 9'd0, 1'b0, tlic_pkg::OFS_FAST_SEL, 32'h0}, 1'b0, '0},
         '{'{tlic_pkg::REQ_READ, 9'd0, 1'b0, chan_addr(31, tlic_pkg::CH_OFS_RAW), 32'h0},
           1'b0, '0}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_rows[i]) begin
         deliver(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
      end
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 87 : 0;
         recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 23 : 0;
         if (phase == 2) begin
            hold_asked++;
         end
         repeat (RANDOM_PER_PHASE) deliver(random_beat(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("two_level_interrupt_controller verification clean");
      end else begin
         $display("two_level_interrupt_controller verification failed");
      end
      $finish;
   end

   // The receiver owns rsp_tready; a requested hold keeps it low for a fixed stretch
   // while the sender keeps offering beats.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_taken != hold_asked) begin
            hold_taken++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rd  = rsp_tdata[tlic_pkg::DATA_W-1:0];
         got.irq = rsp_tdata[tlic_pkg::DATA_W];
         got.fiq = rsp_tdata[tlic_pkg::DATA_W+1];
         if (rsp_due.size() == 0) begin
            $error("response beat with no request outstanding: %h", rsp_tdata);
            fails++;
         end else begin
            want = rsp_due.pop_front();
            if (got.rd !== want.rd) begin
               $error("read_data mismatch: expected %h, got %h", want.rd, got.rd);
               fails++;
            end
            if (got.irq !== want.irq) begin
               $error("irq_out mismatch: expected %b, got %b", want.irq, got.irq);
               fails++;
            end
            if (got.fiq !== want.fiq) begin
               $error("fiq_out mismatch: expected %b, got %b", want.fiq, got.fiq);
               fails++;
            end
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("two_level_interrupt_controller verification failed");
      $finish;
   end

endmodule

[files.f]
rtl/core/tlic_pkg.sv
rtl/core/tlic_front.sv
rtl/core/tlic_queue.sv
rtl/core/tlic_back.sv
rtl/core/two_level_interrupt_controller.sv
rtl/core/tlic_checker.sv
verif/tb.sv
